// ===== src/rtcp_cc_feedback_parser_macros.svh =====
// assertion macros shared by the feedback parser rtl
`ifndef RTCP_CC_FEEDBACK_PARSER_MACROS_SVH
`define RTCP_CC_FEEDBACK_PARSER_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define RCFP_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define RCFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rcfp_pkg.sv =====
// types and constants of the congestion-control feedback parser
package rcfp_pkg;

  // parse position inside one feedback packet
  typedef enum logic [3:0] {
    PH_H0     = 4'd0,
    PH_H1     = 4'd1,
    PH_LEN    = 4'd2,
    PH_SND    = 4'd3,
    PH_BSSRC  = 4'd4,
    PH_BEGIN  = 4'd5,
    PH_END    = 4'd6,
    PH_METRIC = 4'd7,
    PH_PAD    = 4'd8,
    PH_TS     = 4'd9,
    PH_TAIL   = 4'd10
  } phase_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_METRIC  = 2'd0,
    KIND_TRAILER = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_VERSION  = 3'd1,
    ERR_TYPE_FMT = 3'd2,
    ERR_LENGTH   = 3'd3,
    ERR_TRUNC    = 3'd4
  } err_e;

  // configuration register indexes
  localparam logic [1:0] CFG_PKT_TYPE    = 2'd0;
  localparam logic [1:0] CFG_FORMAT      = 2'd1;
  localparam logic [1:0] CFG_UNAVAILABLE = 2'd2;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned OutDataW = 136;

  // protocol constants
  localparam logic [1:0]  RTCP_VERSION    = 2'd2;
  localparam logic [15:0] MIN_LENGTH      = 16'd2;
  localparam logic [16:0] BLOCK_HDR_WORDS = 17'd4;
  localparam logic [15:0] FULL_SEQ_SPAN   = 16'hffff;

  // reset values of the configuration registers
  localparam logic [7:0]  RST_PKT_TYPE    = 8'd205;
  localparam logic [4:0]  RST_FORMAT      = 5'd11;
  localparam logic [12:0] RST_UNAVAILABLE = 13'h1fff;

  // one result item
  typedef struct packed {
    kind_e       kind;
    logic [31:0] sender_ssrc;
    logic [31:0] media_ssrc;
    logic [15:0] sequence_res;
    logic [1:0]  ecn_bits;
    logic [12:0] arrival_offset;
    logic [31:0] report_timestamp;
    err_e        error_code;
  } res_t;

endpackage

// ===== src/rtcp_cc_feedback_parser.sv =====
// rtcp congestion-control feedback parser: byte stream in, metric/trailer/error records out
//
//   channel  | dir | handshake                    | payload
//   s_axis   | in  | tvalid/tready                | tdata = data_byte, tlast = end_of_packet
//   m_axis   | out | tvalid/tready                | tuser = kind, tdata = record fields
//   cfg      | in  | cfg_we_i, no wait            | cfg_addr_i, cfg_wdata_i
//
// one byte is taken every cycle while the output register does not stall; a byte waits in the
// input register and its record, if any, is written into the output register when it is parsed.
// the single-byte parse step between these two registers sets the rate.
// a stalled output register holds the byte in the input register, and s_axis_tready
// drops only while both registers are full. reset returns to the first header byte.
`include "rtcp_cc_feedback_parser_macros.svh"

module rtcp_cc_feedback_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tlast,   // end_of_packet
  // record stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] sender_ssrc, [63:32] media_ssrc, [79:64] sequence_res, [81:80] ecn_bits,
  // [94:82] arrival_offset, [126:95] report_timestamp, [129:127] error_code, rest zero
  output logic [rcfp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,   // [1:0] kind
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [rcfp_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [rcfp_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rcfp_pkg::*;

  // configuration registers
  logic [7:0]  pkt_type_q;
  logic [4:0]  format_q;
  logic [12:0] unavail_q;

  // input register
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;

  // parse state
  phase_e      phase_q, phase_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [31:0] shift_q, shift_d;
  logic [16:0] words_left_q, words_left_d;
  logic [15:0] metrics_left_q, metrics_left_d;
  logic        pad_pending_q, pad_pending_d;
  logic [31:0] sender_id_q, sender_id_d;
  logic [31:0] stream_id_q, stream_id_d;
  logic [15:0] begin_seq_q, begin_seq_d;
  logic [15:0] cur_seq_q, cur_seq_d;
  logic [4:0]  first_fmt_q, first_fmt_d;
  logic        dropping_q, dropping_d;

  // output register
  logic        out_valid_q;
  res_t        out_q;

  // step results
  logic        proc_en;
  logic        res_valid;
  res_t        res;

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_type_q <= RST_PKT_TYPE;
      format_q   <= RST_FORMAT;
      unavail_q  <= RST_UNAVAILABLE;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_PKT_TYPE:    pkt_type_q <= cfg_wdata_i[7:0];
        CFG_FORMAT:      format_q   <= cfg_wdata_i[4:0];
        CFG_UNAVAILABLE: unavail_q  <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  // handshake: a byte is parsed when the output register can take its record
  assign proc_en       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_en;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // one parse step per byte
  always_comb begin
    logic        err;
    err_e        err_code;
    logic        finished;
    logic [15:0] len;
    logic [15:0] diff;
    logic [16:0] cnt;
    logic [16:0] need;
    logic [16:0] wl_after_hdr;
    logic [7:0]  o1;
    logic [12:0] ato;
    phase_e      blk_next;

    err          = 1'b0;
    err_code     = ERR_NONE;
    finished     = 1'b0;
    len          = {shift_q[7:0], in_byte_q};
    diff         = len - begin_seq_q;
    cnt          = {1'b0, diff} + 17'd1;
    need         = cnt + {16'd0, cnt[0]};
    wl_after_hdr = words_left_q - BLOCK_HDR_WORDS;
    o1           = shift_q[7:0];
    ato          = {o1[4:0], in_byte_q};
    blk_next     = (words_left_q == 17'd0) ? PH_TS : PH_BSSRC;

    phase_d        = phase_q;
    byte_idx_d     = byte_idx_q;
    shift_d        = shift_q;
    words_left_d   = words_left_q;
    metrics_left_d = metrics_left_q;
    pad_pending_d  = pad_pending_q;
    sender_id_d    = sender_id_q;
    stream_id_d    = stream_id_q;
    begin_seq_d    = begin_seq_q;
    cur_seq_d      = cur_seq_q;
    first_fmt_d    = first_fmt_q;
    dropping_d     = dropping_q;

    res_valid = 1'b0;
    res       = '0;

    if (dropping_q) begin
      // skip to the end of a failed packet
      if (in_last_q) begin
        phase_d    = PH_H0;
        byte_idx_d = 2'd0;
        dropping_d = 1'b0;
      end
    end else begin
      shift_d = {shift_q[23:0], in_byte_q};
      case (phase_q)
        PH_H0: begin
          first_fmt_d = in_byte_q[4:0];
          if (in_byte_q[7:6] != RTCP_VERSION) begin
            err      = 1'b1;
            err_code = ERR_VERSION;
          end else begin
            phase_d = PH_H1;
          end
        end
        PH_H1: begin
          if (in_byte_q != pkt_type_q || first_fmt_q != format_q) begin
            err      = 1'b1;
            err_code = ERR_TYPE_FMT;
          end else begin
            phase_d    = PH_LEN;
            byte_idx_d = 2'd0;
          end
        end
        PH_LEN: begin
          if (byte_idx_q == 2'd0) begin
            byte_idx_d = 2'd1;
          end else if (len < MIN_LENGTH) begin
            err      = 1'b1;
            err_code = ERR_LENGTH;
          end else begin
            words_left_d = {len - MIN_LENGTH, 1'b0};
            phase_d      = PH_SND;
            byte_idx_d   = 2'd0;
          end
        end
        PH_SND: begin
          if (byte_idx_q != 2'd3) begin
            byte_idx_d = byte_idx_q + 2'd1;
          end else begin
            sender_id_d = shift_d;
            byte_idx_d  = 2'd0;
            phase_d     = blk_next;
          end
        end
        PH_BSSRC: begin
          if (byte_idx_q == 2'd0 && words_left_q < BLOCK_HDR_WORDS) begin
            err      = 1'b1;
            err_code = ERR_LENGTH;
          end else if (byte_idx_q != 2'd3) begin
            byte_idx_d = byte_idx_q + 2'd1;
          end else begin
            stream_id_d = shift_d;
            phase_d     = PH_BEGIN;
            byte_idx_d  = 2'd0;
          end
        end
        PH_BEGIN: begin
          if (byte_idx_q == 2'd0) begin
            byte_idx_d = 2'd1;
          end else begin
            begin_seq_d = len;
            phase_d     = PH_END;
            byte_idx_d  = 2'd0;
          end
        end
        PH_END: begin
          if (byte_idx_q == 2'd0) begin
            byte_idx_d = 2'd1;
          end else if (diff == FULL_SEQ_SPAN) begin
            err      = 1'b1;
            err_code = ERR_LENGTH;
          end else begin
            words_left_d = wl_after_hdr;
            if (wl_after_hdr < need) begin
              err      = 1'b1;
              err_code = ERR_LENGTH;
            end else begin
              words_left_d   = wl_after_hdr - need;
              metrics_left_d = cnt[15:0];
              pad_pending_d  = cnt[0];
              cur_seq_d      = begin_seq_q;
              phase_d        = PH_METRIC;
              byte_idx_d     = 2'd0;
            end
          end
        end
        PH_METRIC: begin
          if (byte_idx_q == 2'd0) begin
            byte_idx_d = 2'd1;
          end else begin
            // received bit set and offset known: emit a metric record
            if (o1[7] && ato != unavail_q) begin
              res_valid          = 1'b1;
              res.kind           = KIND_METRIC;
              res.sender_ssrc    = sender_id_q;
              res.media_ssrc     = stream_id_q;
              res.sequence_res   = cur_seq_q;
              res.ecn_bits       = o1[6:5];
              res.arrival_offset = ato;
            end
            cur_seq_d      = cur_seq_q + 16'd1;
            metrics_left_d = metrics_left_q - 16'd1;
            byte_idx_d     = 2'd0;
            if (metrics_left_q == 16'd1) begin
              phase_d = pad_pending_q ? PH_PAD : blk_next;
            end
          end
        end
        PH_PAD: begin
          if (byte_idx_q == 2'd0) begin
            byte_idx_d = 2'd1;
          end else begin
            pad_pending_d = 1'b0;
            byte_idx_d    = 2'd0;
            phase_d       = blk_next;
          end
        end
        PH_TS: begin
          if (byte_idx_q != 2'd3) begin
            byte_idx_d = byte_idx_q + 2'd1;
          end else begin
            res_valid            = 1'b1;
            res.kind             = KIND_TRAILER;
            res.sender_ssrc      = sender_id_q;
            res.report_timestamp = shift_d;
            finished             = 1'b1;
            phase_d              = PH_TAIL;
            byte_idx_d           = 2'd0;
          end
        end
        default: begin
          // byte past the report timestamp
          err      = 1'b1;
          err_code = ERR_TRUNC;
        end
      endcase

      // end flag anywhere but on the last timestamp byte
      if (!err && in_last_q && !finished) begin
        err      = 1'b1;
        err_code = ERR_TRUNC;
      end

      if (err) begin
        res_valid      = 1'b1;
        res            = '0;
        res.kind       = KIND_ERROR;
        res.error_code = err_code;
        if (!in_last_q) begin
          dropping_d = 1'b1;
        end
      end

      if (in_last_q) begin
        phase_d    = PH_H0;
        byte_idx_d = 2'd0;
        dropping_d = 1'b0;
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_H0;
      byte_idx_q     <= 2'd0;
      shift_q        <= '0;
      words_left_q   <= '0;
      metrics_left_q <= '0;
      pad_pending_q  <= 1'b0;
      sender_id_q    <= '0;
      stream_id_q    <= '0;
      begin_seq_q    <= '0;
      cur_seq_q      <= '0;
      first_fmt_q    <= '0;
      dropping_q     <= 1'b0;
    end else if (proc_en) begin
      phase_q        <= phase_d;
      byte_idx_q     <= byte_idx_d;
      shift_q        <= shift_d;
      words_left_q   <= words_left_d;
      metrics_left_q <= metrics_left_d;
      pad_pending_q  <= pad_pending_d;
      sender_id_q    <= sender_id_d;
      stream_id_q    <= stream_id_d;
      begin_seq_q    <= begin_seq_d;
      cur_seq_q      <= cur_seq_d;
      first_fmt_q    <= first_fmt_d;
      dropping_q     <= dropping_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_en) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_en && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {6'd0, out_q.error_code, out_q.report_timestamp,
                          out_q.arrival_offset, out_q.ecn_bits, out_q.sequence_res,
                          out_q.media_ssrc, out_q.sender_ssrc};

  // report block word counts stay even
  `RCFP_ASSERT(a_words_even, !words_left_q[0], "odd report block word count")
  // a metric phase always has metrics to go
  `RCFP_ASSERT_IMP(a_metrics_nonzero, phase_q == PH_METRIC, metrics_left_q != 16'd0,
                   "metric phase with no metrics left")
  // nothing is emitted while dropping a failed packet
  `RCFP_ASSERT_IMP(a_drop_silent, proc_en && dropping_q, !res_valid,
                   "record emitted while dropping")
  // an error record always carries a code
  `RCFP_ASSERT_IMP(a_err_code, res_valid && res.kind == KIND_ERROR,
                   res.error_code != ERR_NONE, "error record without code")
  // a held byte stays in the input register
  `RCFP_ASSERT_NXT(a_in_hold, in_valid_q && !proc_en,
                   in_valid_q && $stable(in_byte_q) && $stable(in_last_q), "held byte lost")

endmodule
